// ===== rtl/sud_pkg.sv =====
package sud_pkg;

  localparam int COORD_W  = 16;
  localparam int RAD_W    = 15;
  localparam int IDX_IN_W = 3;
  localparam int CFG_W    = 4;
  localparam int MAG_W    = 16;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SQ_W     = PROD_W + 2;
  localparam int ROOT_W   = 17;
  localparam int DIST_W   = 18;

  localparam int DEF_MAX_SPHERES = 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic signed [COORD_W-1:0] DIST_MAX = 16'sh7fff;

  // highest even bit position of the squared sum starts the root recurrence
  localparam logic [SQ_W-1:0] ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RAD_W-1:0]          radius;
  } sphere_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

// ===== rtl/sud_table.sv =====
module sud_table
  import sud_pkg::*;
#(
  parameter int MAX_SPHERES = DEF_MAX_SPHERES,
  parameter int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sphere_t       wr_data,
  input  logic [AW-1:0] rd_addr,
  output sphere_t       rd_data
);

  sphere_t mem [MAX_SPHERES];
  sphere_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sud_root.sv =====
module sud_root
  import sud_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output root_stat_t        stat,
  output logic [ROOT_W-1:0] root
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [SQ_W-1:0] v_r, v_nxt;
  logic [SQ_W-1:0] res_r, res_nxt;
  logic [SQ_W-1:0] bit_r, bit_nxt;
  logic [SQ_W:0]   trial;

  // one result bit per cycle: compare against res + bit, subtract on success
  assign trial = {1'b0, res_r} + {1'b0, bit_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = value;
      res_nxt  = '0;
      bit_nxt  = ROOT_BIT_INIT;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= trial) begin
        v_nxt   = v_r - trial[SQ_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[ROOT_W-1:0];

endmodule

// ===== rtl/sphere_union_distance_top.sv =====
// Load: no result; busy stays low.
// Query: out_valid rises after the compare of the last active sphere; with no active spheres, the cycle after start.
// Each sphere costs one table read, a pass of the shared squarer over the three axes, one root start,
// the bit-serial square root and one compare; busy is high throughout.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Synchronous active-low reset clears the sequencer and the sphere count (count_r); table contents persist.
module sphere_union_distance_top
  import sud_pkg::*;
#(
  parameter int MAX_SPHERES = DEF_MAX_SPHERES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic [IDX_IN_W-1:0]       in_sphere_index,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic signed [COORD_W-1:0] in_pos_z,
  input  logic [RAD_W-1:0]          in_radius,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_min_distance
);

  localparam int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FETCH  = 6'b000010,
    ST_SQ     = 6'b000100,
    ST_RSTART = 6'b001000,
    ST_RWAIT  = 6'b010000,
    ST_CMP    = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CFG_W-1:0]          count_r;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [2:0]                step_r, step_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt;
  logic signed [COORD_W-1:0] py_r, py_nxt;
  logic signed [COORD_W-1:0] pz_r, pz_nxt;
  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [SQ_W-1:0]           sum_r, sum_nxt;
  logic signed [DIST_W-1:0]  best_r, best_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] out_dist_r, out_dist_nxt;

  logic                      accept;
  logic                      tbl_we;
  sphere_t                   tbl_wdata;
  sphere_t                   entry;
  logic signed [COORD_W-1:0] p_sel, c_sel;
  logic signed [COORD_W:0]   diff;
  logic signed [DIST_W-1:0]  surf_dist;
  logic signed [DIST_W-1:0]  best_new;
  logic                      root_start;
  root_stat_t                root_stat;
  logic [ROOT_W-1:0]         root;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign tbl_we = accept && (in_opcode == OP_LOAD) && (int'(in_sphere_index) < MAX_SPHERES);

  assign tbl_wdata.x      = in_pos_x;
  assign tbl_wdata.y      = in_pos_y;
  assign tbl_wdata.z      = in_pos_z;
  assign tbl_wdata.radius = in_radius;

  sud_table #(
    .MAX_SPHERES (MAX_SPHERES),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (AW'(in_sphere_index)),
    .wr_data (tbl_wdata),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (entry)
  );

  sud_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (sum_r),
    .stat  (root_stat),
    .root  (root)
  );

  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        p_sel = px_r;
        c_sel = entry.x;
      end
      2'd1: begin
        p_sel = py_r;
        c_sel = entry.y;
      end
      default: begin
        p_sel = pz_r;
        c_sel = entry.z;
      end
    endcase
  end

  assign diff      = {p_sel[COORD_W-1], p_sel} - {c_sel[COORD_W-1], c_sel};
  assign surf_dist = $signed({1'b0, root}) - $signed({{(DIST_W-RAD_W){1'b0}}, entry.radius});
  assign best_new  = (surf_dist < best_r) ? surf_dist : best_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    out_valid_nxt = 1'b0;
    out_dist_nxt  = out_dist_r;
    root_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_opcode == OP_QUERY)) begin
          px_nxt   = in_pos_x;
          py_nxt   = in_pos_y;
          pz_nxt   = in_pos_z;
          idx_nxt  = '0;
          best_nxt = DIST_W'(DIST_MAX);
          if (int'(count_r) > MAX_SPHERES) begin
            n_nxt = CNT_W'(MAX_SPHERES);
          end else begin
            n_nxt = CNT_W'(count_r);
          end
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_dist_nxt  = DIST_MAX;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        step_nxt  = '0;
        sum_nxt   = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        // overlap: difference, square and accumulate of consecutive axes
        mag_nxt  = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);
        prod_nxt = mag_r * mag_r;
        if (step_r >= 3'd2) begin
          sum_nxt = sum_r + SQ_W'(prod_r);
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd4) begin
          state_nxt = ST_RSTART;
        end
      end
      ST_RSTART: begin
        root_start = 1'b1;
        state_nxt  = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (root_stat.done) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        best_nxt = best_new;
        if (CNT_W'(idx_r + 1'b1) == n_r) begin
          // best starts at the positive limit and the surface distance is never below -radius,
          // so the minimum always fits the result width
          out_valid_nxt = 1'b1;
          out_dist_nxt  = best_new[COORD_W-1:0];
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt   = CNT_W'(idx_r + 1'b1);
          state_nxt = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    step_r     <= step_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    best_r     <= best_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_min_distance = out_dist_r;

`ifndef SYNTH
  a_root_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RWAIT) |-> (root_stat.busy || root_stat.done))
    else $error("root unit idle while sequencer waits on it");

  a_root_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    root_stat.done |-> (state_r == ST_RWAIT))
    else $error("root finished outside the wait state");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ || state_r == ST_CMP) |-> (idx_r < n_r))
    else $error("sphere index beyond active count");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_LOAD)) |=> !out_valid_r)
    else $error("load produced a result");

  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && $past(state_r) == ST_CMP) |-> (state_r == ST_IDLE))
    else $error("result strobed while query still running");
`endif

endmodule
